@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked checks on clk with synchronous active-low reset rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define DHD_CHECK_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication
`define DHD_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

@@ sv/dhd_pkg.sv @@
// ----------------------------------------------------------------------------
// dhd_pkg
// Shared widths, register indexes, reset values and helpers of the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dhd_pkg;

  localparam int MAX_CLASSES_DEF = 256;

  // shared multiplier operand widths
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_CONF_THR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_PTS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DQ_SCALES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDES    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PADS       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MODEL_SIZE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE  = 3'd6;

  localparam logic [15:0] CONF_THR_RST   = 16'd16384;
  localparam logic [23:0] ZERO_PTS_RST   = 24'd0;
  localparam logic [47:0] DQ_SCALES_RST  = 48'd0;
  localparam logic [15:0] STRIDES_RST    = 16'h0808;
  localparam logic [31:0] PADS_RST       = 32'd0;
  localparam logic [31:0] MODEL_SIZE_RST = 32'h0280_0280;
  localparam logic [15:0] INV_SCALE_RST  = 16'h1000;

  localparam logic [13:0] COORD_MAX = 14'h3FFF;
  localparam logic [15:0] SCORE_MAX = 16'hFFFF;

  typedef struct packed {
    logic                      en;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

  // (code - zero point), sign-extended to the multiplier A width
  function automatic logic signed [MUL_A_W-1:0] dq_diff(input logic [7:0] code,
                                                        input logic [7:0] zp);
    logic signed [8:0] d;
    d = $signed({code[7], code}) - $signed({zp[7], zp});
    return {{(MUL_A_W-9){d[8]}}, d};
  endfunction

  // unsigned 16-bit value as a positive B operand
  function automatic logic signed [MUL_B_W-1:0] ub16(input logic [15:0] v);
    return $signed({1'b0, v});
  endfunction

endpackage

@@ sv/dhd_mul.sv @@
// ----------------------------------------------------------------------------
// dhd_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dhd_mul (
  input  logic                                   clk,
  input  dhd_pkg::mul_req_t                      req,
  output logic signed [dhd_pkg::MUL_P_W-1:0]     prod_r
);
  import dhd_pkg::*;

  logic signed [MUL_P_W-1:0] prod_nxt;

  assign prod_nxt = MUL_P_W'(req.a) * MUL_P_W'(req.b);

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

@@ sv/detection_head_decoder.sv @@
// ----------------------------------------------------------------------------
// detection_head_decoder
// Per-cell class argmax and anchor-free box decode of an int8 detection head.
// ----------------------------------------------------------------------------
// One item is taken at a time; in_tready is low while it is worked on. A class
// item that is not the last of its cell visits ST_CLS only; the last also visits
// ST_OBJ and, for a box, ST_DQB, ST_POS, ST_STR, ST_CLP, ST_INV and ST_WR per
// corner, then ST_FIN, plus any wait for the output register to drain. All
// products go through a single shared 33x17 multiplier: one for each class score,
// one for objectness per class item, three per box corner (distance dequantize,
// stride, inverse scale). The result sits in an output register, so the next
// item is accepted while a box waits on out_tready; reset runs no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module detection_head_decoder #(
  parameter int MAX_CLASSES = dhd_pkg::MAX_CLASSES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // row, col, objectness_code, dist_left, dist_top, dist_right, dist_bottom,
  // class_code (8 bits each)
  input  logic [63:0]                        in_tdata,
  input  logic                               in_tlast,   // last_class
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // winning class (8), score (16), left_x, top_y, right_x, bottom_y (14 each)
  output logic [79:0]                        out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dhd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dhd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dhd_pkg::*;

  localparam int CIDX_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLS, ST_OBJ, ST_DQB, ST_POS, ST_STR, ST_CLP, ST_INV, ST_WR, ST_FIN
  } state_t;

  state_t                    state_r, state_nxt;
  logic [1:0]                k_r, k_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [79:0]               out_data_r, out_data_nxt;
  logic [23:0]               best_score_r, best_score_nxt;
  logic [CIDX_W-1:0]         best_class_r, best_class_nxt;
  logic                      has_class_r, has_class_nxt;
  logic [CIDX_W-1:0]         class_index_r, class_index_nxt;

  logic [15:0]               conf_thr_r, conf_thr_nxt;
  logic [23:0]               zero_pts_r, zero_pts_nxt;
  logic [47:0]               dq_scales_r, dq_scales_nxt;
  logic [15:0]               strides_r, strides_nxt;
  logic [31:0]               pads_r, pads_nxt;
  logic [31:0]               model_size_r, model_size_nxt;
  logic [15:0]               inv_scale_r, inv_scale_nxt;

  logic [7:0]                row_r, row_nxt;
  logic [7:0]                col_r, col_nxt;
  logic [7:0]                obj_r, obj_nxt;
  logic [7:0]                dist_r [4];
  logic [7:0]                dist_nxt [4];
  logic                      last_r, last_nxt;
  logic signed [MUL_A_W-1:0] acc_r, acc_nxt;
  logic [13:0]               corner_r [4];
  logic [13:0]               corner_nxt [4];

  mul_req_t                  mreq;
  logic signed [MUL_P_W-1:0] prod_r;

  logic                      in_xfer;
  logic                      out_free;
  logic                      emit;
  logic signed [MUL_A_W-1:0] cpos;
  logic signed [MUL_A_W-1:0] dlow;
  logic signed [MUL_P_W-1:0] pad_q;
  logic signed [MUL_P_W-1:0] lim_q;
  logic signed [MUL_P_W-1:0] vpos;
  logic [15:0]               score_sat;

  dhd_mul u_mul (
    .clk    (clk),
    .req    (mreq),
    .prod_r (prod_r)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  assign emit = ($signed(prod_r) >= $signed({{(MUL_P_W-16){1'b0}}, conf_thr_r}))
             && has_class_r && (best_score_r > {8'b0, conf_thr_r});

  assign cpos  = $signed({9'b0, (k_r[0] ? row_r : col_r), 16'h8000});
  assign dlow  = prod_r[MUL_A_W-1:0];
  assign pad_q = $signed({18'b0, (k_r[0] ? pads_r[31:16] : pads_r[15:0]), 16'b0});
  assign lim_q = $signed({18'b0, (k_r[0] ? model_size_r[31:16] : model_size_r[15:0]),
                          16'b0});
  assign vpos  = prod_r - pad_q;
  assign score_sat = (best_score_r[23:16] != 8'd0) ? SCORE_MAX : best_score_r[15:0];

  // shared multiplier operand select
  always_comb begin
    mreq = '0;
    case (state_r)
      ST_IDLE: begin
        mreq.en = in_xfer;
        mreq.a  = dq_diff(in_tdata[63:56], zero_pts_r[15:8]);
        mreq.b  = ub16(dq_scales_r[31:16]);
      end
      ST_CLS: begin
        mreq.en = 1'b1;
        mreq.a  = dq_diff(obj_r, zero_pts_r[7:0]);
        mreq.b  = ub16(dq_scales_r[15:0]);
      end
      ST_DQB: begin
        mreq.en = 1'b1;
        mreq.a  = dq_diff(dist_r[k_r], zero_pts_r[23:16]);
        mreq.b  = ub16(dq_scales_r[47:32]);
      end
      ST_STR: begin
        mreq.en = 1'b1;
        mreq.a  = acc_r;
        mreq.b  = ub16({8'b0, (k_r[0] ? strides_r[15:8] : strides_r[7:0])});
      end
      ST_INV: begin
        mreq.en = 1'b1;
        mreq.a  = acc_r;
        mreq.b  = ub16(inv_scale_r);
      end
      default: begin
        mreq = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    k_nxt           = k_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_data_nxt    = out_data_r;
    best_score_nxt  = best_score_r;
    best_class_nxt  = best_class_r;
    has_class_nxt   = has_class_r;
    class_index_nxt = class_index_r;
    conf_thr_nxt    = conf_thr_r;
    zero_pts_nxt    = zero_pts_r;
    dq_scales_nxt   = dq_scales_r;
    strides_nxt     = strides_r;
    pads_nxt        = pads_r;
    model_size_nxt  = model_size_r;
    inv_scale_nxt   = inv_scale_r;
    row_nxt         = row_r;
    col_nxt         = col_r;
    obj_nxt         = obj_r;
    dist_nxt        = dist_r;
    last_nxt        = last_r;
    acc_nxt         = acc_r;
    corner_nxt      = corner_r;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CONF_THR:   conf_thr_nxt   = cfg_data[15:0];
        REG_ZERO_PTS:   zero_pts_nxt   = cfg_data[23:0];
        REG_DQ_SCALES:  dq_scales_nxt  = cfg_data[47:0];
        REG_STRIDES:    strides_nxt    = cfg_data[15:0];
        REG_PADS:       pads_nxt       = cfg_data[31:0];
        REG_MODEL_SIZE: model_size_nxt = cfg_data[31:0];
        REG_INV_SCALE:  inv_scale_nxt  = cfg_data[15:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          row_nxt     = in_tdata[7:0];
          col_nxt     = in_tdata[15:8];
          obj_nxt     = in_tdata[23:16];
          dist_nxt[0] = in_tdata[31:24];
          dist_nxt[1] = in_tdata[39:32];
          dist_nxt[2] = in_tdata[47:40];
          dist_nxt[3] = in_tdata[55:48];
          last_nxt    = in_tlast;
          state_nxt   = ST_CLS;
        end
      end
      ST_CLS: begin
        if ($signed(prod_r) > $signed({{(MUL_P_W-24){1'b0}}, best_score_r})) begin
          best_score_nxt = prod_r[23:0];
          best_class_nxt = class_index_r;
          has_class_nxt  = 1'b1;
        end
        class_index_nxt = (class_index_r == CIDX_W'(MAX_CLASSES - 1)) ? '0
                        : class_index_r + 1'b1;
        state_nxt = last_r ? ST_OBJ : ST_IDLE;
      end
      ST_OBJ: begin
        if (emit) begin
          k_nxt     = 2'd0;
          state_nxt = ST_DQB;
        end else begin
          best_score_nxt  = '0;
          best_class_nxt  = '0;
          has_class_nxt   = 1'b0;
          class_index_nxt = '0;
          state_nxt       = ST_IDLE;
        end
      end
      ST_DQB: begin
        state_nxt = ST_POS;
      end
      ST_POS: begin
        // left and top subtract the distance, right and bottom add it
        acc_nxt   = k_r[1] ? (cpos + dlow) : (cpos - dlow);
        state_nxt = ST_STR;
      end
      ST_STR: begin
        state_nxt = ST_CLP;
      end
      ST_CLP: begin
        if (vpos < 0) begin
          acc_nxt = '0;
        end else if (vpos > lim_q) begin
          acc_nxt = lim_q[MUL_A_W-1:0];
        end else begin
          acc_nxt = vpos[MUL_A_W-1:0];
        end
        state_nxt = ST_INV;
      end
      ST_INV: begin
        state_nxt = ST_WR;
      end
      ST_WR: begin
        corner_nxt[k_r] = (prod_r[47:42] != 6'd0) ? COORD_MAX : prod_r[41:28];
        if (k_r == 2'd3) begin
          k_nxt     = 2'd0;
          state_nxt = ST_FIN;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = ST_DQB;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_data_nxt    = {corner_r[3], corner_r[2], corner_r[1], corner_r[0],
                             score_sat, 8'(best_class_r)};
          best_score_nxt  = '0;
          best_class_nxt  = '0;
          has_class_nxt   = 1'b0;
          class_index_nxt = '0;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      k_r           <= 2'd0;
      out_valid_r   <= 1'b0;
      best_score_r  <= '0;
      best_class_r  <= '0;
      has_class_r   <= 1'b0;
      class_index_r <= '0;
      conf_thr_r    <= CONF_THR_RST;
      zero_pts_r    <= ZERO_PTS_RST;
      dq_scales_r   <= DQ_SCALES_RST;
      strides_r     <= STRIDES_RST;
      pads_r        <= PADS_RST;
      model_size_r  <= MODEL_SIZE_RST;
      inv_scale_r   <= INV_SCALE_RST;
    end else begin
      state_r       <= state_nxt;
      k_r           <= k_nxt;
      out_valid_r   <= out_valid_nxt;
      best_score_r  <= best_score_nxt;
      best_class_r  <= best_class_nxt;
      has_class_r   <= has_class_nxt;
      class_index_r <= class_index_nxt;
      conf_thr_r    <= conf_thr_nxt;
      zero_pts_r    <= zero_pts_nxt;
      dq_scales_r   <= dq_scales_nxt;
      strides_r     <= strides_nxt;
      pads_r        <= pads_nxt;
      model_size_r  <= model_size_nxt;
      inv_scale_r   <= inv_scale_nxt;
    end
    out_data_r <= out_data_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    obj_r      <= obj_nxt;
    dist_r     <= dist_nxt;
    last_r     <= last_nxt;
    acc_r      <= acc_nxt;
    corner_r   <= corner_nxt;
  end

  `DHD_CHECK_SAME(a_idle_corner_zero, state_r == ST_IDLE, k_r == 2'd0)
  `DHD_CHECK_SAME(a_best_has_class, has_class_r, best_score_r != 24'd0)
  `DHD_CHECK_SAME(a_best_empty, !has_class_r, best_score_r == 24'd0)
  `DHD_CHECK_NEXT(a_busy_after_take, in_tvalid && in_tready, !in_tready)
  `DHD_CHECK_SAME(a_out_from_fin, $rose(out_valid_r), $past(state_r) == ST_FIN)

endmodule
